### design/scc_pkg.sv
// Shared types and constants for the segment crossing counter.
package scc_pkg;

   // Width of the reported crossing count; the count saturates at all ones.
   localparam int COUNT_BITS = 16;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_I,
      ST_LATCH_I,
      ST_SWEEP,
      ST_DRAIN,
      ST_DONE
   } scc_state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic load;      // store the edge on the request ports
      logic read_i;    // read the outer edge from the store
      logic latch_i;   // capture the outer edge from the read data
      logic read_j;    // read the next inner edge into the pair pipeline
      logic emit;      // result transfer this cycle; empty the store
   } scc_cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic j_last;    // inner index is on the last stored edge
      logic i_last;    // outer index is on the last stored edge
      logic pipe_busy; // pair pipeline still holds work
   } scc_stat_type;

endpackage

### design/scc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module scc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

### design/scc_ctrl.sv
// Controller state machine: edge loading, pairwise sweep sequencing, result transfer.
module scc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  last_edge,
   input  scc_pkg::scc_stat_type stat,
   output scc_pkg::scc_cmd_type  cmd,
   output logic                  busy,
   output logic                  rsp_valid
);

   scc_pkg::scc_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         scc_pkg::ST_IDLE: begin
            if (start && last_edge) state_in = scc_pkg::ST_READ_I;
         end
         scc_pkg::ST_READ_I:  state_in = scc_pkg::ST_LATCH_I;
         scc_pkg::ST_LATCH_I: state_in = scc_pkg::ST_SWEEP;
         scc_pkg::ST_SWEEP: begin
            if (stat.j_last) begin
               state_in = stat.i_last ? scc_pkg::ST_DRAIN : scc_pkg::ST_READ_I;
            end
         end
         scc_pkg::ST_DRAIN: begin
            if (!stat.pipe_busy) state_in = scc_pkg::ST_DONE;
         end
         scc_pkg::ST_DONE: state_in = scc_pkg::ST_IDLE;
         default:          state_in = scc_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         scc_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         scc_pkg::ST_READ_I:  cmd.read_i  = 1'b1;
         scc_pkg::ST_LATCH_I: cmd.latch_i = 1'b1;
         scc_pkg::ST_SWEEP:   cmd.read_j  = 1'b1;
         scc_pkg::ST_DRAIN:   cmd         = '0;
         scc_pkg::ST_DONE: begin
            cmd.emit  = 1'b1;
            rsp_valid = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

   // The block is free again right after a result transfer
   a_free_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("busy after result transfer");

   // A sweep only ends through a result transfer
   a_busy_ends_with_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> $past(rsp_valid))
      else $error("busy dropped without a result");

endmodule

### design/scc_dp.sv
// Datapath: edge store, sweep indexes, pair-test pipeline and crossing counter.
module scc_dp #(
   parameter int MAX_EDGES   = 256,
   parameter int COORD_BITS  = 16,
   parameter int VERTEX_BITS = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  scc_pkg::scc_cmd_type                 cmd,
   output scc_pkg::scc_stat_type                stat,
   input  logic [COORD_BITS-1:0]                x_start,
   input  logic [COORD_BITS-1:0]                y_start,
   input  logic [COORD_BITS-1:0]                x_end,
   input  logic [COORD_BITS-1:0]                y_end,
   input  logic [VERTEX_BITS-1:0]               vertex_start,
   input  logic [VERTEX_BITS-1:0]               vertex_end,
   output logic [scc_pkg::COUNT_BITS-1:0]       crossing_count,
   output logic                                 edges_dropped
);

   localparam int AW = $clog2(MAX_EDGES);
   localparam int HW = AW + 1;
   localparam int CB = COORD_BITS;
   localparam int VB = VERTEX_BITS;
   localparam int W  = 4 * CB + 2 * VB;
   localparam int D  = CB + 1;           // signed coordinate difference
   localparam int P  = 2 * D;            // product
   localparam int CW = scc_pkg::COUNT_BITS;

   logic [HW-1:0] held_ff, held_in;
   logic          over_ff, over_in;
   logic [AW-1:0] i_ff, i_in, j_ff, j_in;
   logic          full;
   logic [W-1:0]  rd_data;
   logic [W-1:0]  s_ff;

   // Store bookkeeping and sweep indexes
   assign full        = (held_ff == HW'(MAX_EDGES));
   assign stat.j_last = (({1'b0, j_ff} + HW'(1)) == held_ff);
   assign stat.i_last = (({1'b0, i_ff} + HW'(1)) == held_ff);

   always_comb begin
      held_in = held_ff;
      over_in = over_ff;
      i_in    = i_ff;
      j_in    = j_ff;
      if (cmd.load) begin
         if (full) over_in = 1'b1;
         else      held_in = held_ff + HW'(1);
      end
      if (cmd.read_j) begin
         if (stat.j_last) begin
            j_in = '0;
            i_in = stat.i_last ? '0 : i_ff + AW'(1);
         end else begin
            j_in = j_ff + AW'(1);
         end
      end
      if (cmd.emit) begin
         held_in = '0;
         over_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         over_ff <= 1'b0;
         i_ff    <= '0;
         j_ff    <= '0;
      end else begin
         held_ff <= held_in;
         over_ff <= over_in;
         i_ff    <= i_in;
         j_ff    <= j_in;
      end
   end

   // Edge store: endpoints and vertex numbers packed in one word
   scc_ram #(
      .WIDTH (W),
      .DEPTH (MAX_EDGES)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.load && !full),
      .wr_addr (held_ff[AW-1:0]),
      .wr_data ({x_start, y_start, x_end, y_end, vertex_start, vertex_end}),
      .rd_en   (cmd.read_i || cmd.read_j),
      .rd_addr (cmd.read_i ? i_ff : j_ff),
      .rd_data (rd_data)
   );

   // Outer edge register
   always_ff @(posedge clock) begin
      if (cmd.latch_i) begin
         s_ff <= rd_data;
      end
   end

   // Unpack outer (s) and inner (t) edges
   logic [CB-1:0] s_x0, s_y0, s_x1, s_y1, t_x0, t_y0, t_x1, t_y1;
   logic [VB-1:0] s_v0, s_v1, t_v0, t_v1;

   assign s_x0 = s_ff[W-1 -: CB];
   assign s_y0 = s_ff[W-1-CB -: CB];
   assign s_x1 = s_ff[W-1-2*CB -: CB];
   assign s_y1 = s_ff[W-1-3*CB -: CB];
   assign s_v0 = s_ff[2*VB-1 -: VB];
   assign s_v1 = s_ff[VB-1:0];
   assign t_x0 = rd_data[W-1 -: CB];
   assign t_y0 = rd_data[W-1-CB -: CB];
   assign t_x1 = rd_data[W-1-2*CB -: CB];
   assign t_y1 = rd_data[W-1-3*CB -: CB];
   assign t_v0 = rd_data[2*VB-1 -: VB];
   assign t_v1 = rd_data[VB-1:0];

   // Stage 1: adjacency, bounding-box tests and multiplier operands
   logic                v1_ff;
   logic                v2_ff, v2_in;
   logic signed [D-1:0] opa_ff [8];
   logic signed [D-1:0] opb_ff [8];
   logic signed [D-1:0] opa_in [8];
   logic signed [D-1:0] opb_in [8];
   logic [3:0]          box2_ff, box2_in;

   always_comb begin
      logic signed [D-1:0] sx0, sy0, sx1, sy1, tx0, ty0, tx1, ty1;
      logic [CB-1:0]       slx, shx, sly, shy, tlx, thx, tly, thy;
      logic                adj;
      sx0 = $signed({1'b0, s_x0});
      sy0 = $signed({1'b0, s_y0});
      sx1 = $signed({1'b0, s_x1});
      sy1 = $signed({1'b0, s_y1});
      tx0 = $signed({1'b0, t_x0});
      ty0 = $signed({1'b0, t_y0});
      tx1 = $signed({1'b0, t_x1});
      ty1 = $signed({1'b0, t_y1});
      adj = (s_v0 == t_v0) || (s_v0 == t_v1) || (s_v1 == t_v0) || (s_v1 == t_v1);
      v2_in = v1_ff && !adj;
      // orientation of t0, t1 against s, then of s0, s1 against t
      opa_in[0] = sx1 - sx0;  opb_in[0] = ty0 - sy0;
      opa_in[1] = sy1 - sy0;  opb_in[1] = tx0 - sx0;
      opa_in[2] = sx1 - sx0;  opb_in[2] = ty1 - sy0;
      opa_in[3] = sy1 - sy0;  opb_in[3] = tx1 - sx0;
      opa_in[4] = tx1 - tx0;  opb_in[4] = sy0 - ty0;
      opa_in[5] = ty1 - ty0;  opb_in[5] = sx0 - tx0;
      opa_in[6] = tx1 - tx0;  opb_in[6] = sy1 - ty0;
      opa_in[7] = ty1 - ty0;  opb_in[7] = sx1 - tx0;
      // boxes of both segments
      slx = (s_x0 < s_x1) ? s_x0 : s_x1;
      shx = (s_x0 < s_x1) ? s_x1 : s_x0;
      sly = (s_y0 < s_y1) ? s_y0 : s_y1;
      shy = (s_y0 < s_y1) ? s_y1 : s_y0;
      tlx = (t_x0 < t_x1) ? t_x0 : t_x1;
      thx = (t_x0 < t_x1) ? t_x1 : t_x0;
      tly = (t_y0 < t_y1) ? t_y0 : t_y1;
      thy = (t_y0 < t_y1) ? t_y1 : t_y0;
      box2_in[0] = (t_x0 >= slx) && (t_x0 <= shx) && (t_y0 >= sly) && (t_y0 <= shy);
      box2_in[1] = (t_x1 >= slx) && (t_x1 <= shx) && (t_y1 >= sly) && (t_y1 <= shy);
      box2_in[2] = (s_x0 >= tlx) && (s_x0 <= thx) && (s_y0 >= tly) && (s_y0 <= thy);
      box2_in[3] = (s_x1 >= tlx) && (s_x1 <= thx) && (s_y1 >= tly) && (s_y1 <= thy);
   end

   // Stage 2: products
   logic                v3_ff;
   logic signed [P-1:0] prod_ff [8];
   logic signed [P-1:0] prod_in [8];
   logic [3:0]          box3_ff;

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         prod_in[k] = opa_ff[k] * opb_ff[k];
      end
   end

   // Stage 3: orientation signs and the closed-segment test
   logic hit_ff, hit_in;

   always_comb begin
      logic signed [P:0] ov;
      logic [3:0]        neg, zer;
      logic              straddle;
      for (int m = 0; m < 4; m++) begin
         ov     = (P+1)'(prod_ff[2*m]) - (P+1)'(prod_ff[2*m+1]);
         neg[m] = ov[P];
         zer[m] = (ov == '0);
      end
      straddle = !zer[0] && !zer[1] && (neg[0] != neg[1]) &&
                 !zer[2] && !zer[3] && (neg[2] != neg[3]);
      hit_in = v3_ff && (straddle || |(zer & box3_ff));
   end

   // Stage 4: saturating count
   logic [CW-1:0] count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (hit_ff && (count_ff != '1)) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.emit) begin
         count_in = '0;
      end
   end

   // Pipeline payload registers
   always_ff @(posedge clock) begin
      for (int k = 0; k < 8; k++) begin
         opa_ff[k]  <= opa_in[k];
         opb_ff[k]  <= opb_in[k];
         prod_ff[k] <= prod_in[k];
      end
      box2_ff <= box2_in;
      box3_ff <= box2_ff;
   end

   // Pipeline control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         hit_ff   <= 1'b0;
         count_ff <= '0;
      end else begin
         v1_ff    <= cmd.read_j;
         v2_ff    <= v2_in;
         v3_ff    <= v2_ff;
         hit_ff   <= hit_in;
         count_ff <= count_in;
      end
   end

   assign stat.pipe_busy = v1_ff || v2_ff || v3_ff || hit_ff;
   assign crossing_count = count_ff;
   assign edges_dropped  = over_ff;

   // Fill count never passes the store depth
   a_held_range: assert property (@(posedge clock) disable iff (reset)
      held_ff <= HW'(MAX_EDGES))
      else $error("edge count beyond store depth");

   // Loading never overlaps pair work
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !stat.pipe_busy)
      else $error("edge load while pair pipeline busy");

   // Result only once every pair has reached the counter
   a_emit_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !stat.pipe_busy)
      else $error("result transfer with pairs in flight");

endmodule

### design/segment_crossing_counter_unit.sv
// Top level of the segment crossing counter: controller plus datapath.
// Edges are loaded one per cycle: busy stays low while edges without last_edge
// arrive, and each is stored. The edge with last_edge set starts the pairwise
// sweep: for each of the N stored edges the outer edge is read from the edge
// store (states READ_I, then LATCH_I) and then every stored edge streams past it from
// the same single read port, one per cycle, followed by the pipeline drain and
// the result transfer; the store's one read port sets the length of the sweep.
// The result is on rsp_crossing_count and rsp_edges_dropped for the single cycle
// in which rsp_valid is high and cannot be stalled; busy drops in the cycle after
// it. Edges beyond MAX_EDGES are dropped and flagged.
module segment_crossing_counter_unit #(
   parameter int MAX_EDGES   = 256,
   parameter int COORD_BITS  = 16,
   parameter int VERTEX_BITS = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [COORD_BITS-1:0]          req_x_start,
   input  logic [COORD_BITS-1:0]          req_y_start,
   input  logic [COORD_BITS-1:0]          req_x_end,
   input  logic [COORD_BITS-1:0]          req_y_end,
   input  logic [VERTEX_BITS-1:0]         req_vertex_start,
   input  logic [VERTEX_BITS-1:0]         req_vertex_end,
   input  logic                           req_last_edge,
   output logic                           rsp_valid,
   output logic [scc_pkg::COUNT_BITS-1:0] rsp_crossing_count,
   output logic                           rsp_edges_dropped
);

   scc_pkg::scc_cmd_type  cmd;
   scc_pkg::scc_stat_type stat;

   // Sequencing
   scc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .last_edge (req_last_edge),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Store, pair test and count
   scc_dp #(
      .MAX_EDGES   (MAX_EDGES),
      .COORD_BITS  (COORD_BITS),
      .VERTEX_BITS (VERTEX_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .x_start        (req_x_start),
      .y_start        (req_y_start),
      .x_end          (req_x_end),
      .y_end          (req_y_end),
      .vertex_start   (req_vertex_start),
      .vertex_end     (req_vertex_end),
      .crossing_count (rsp_crossing_count),
      .edges_dropped  (rsp_edges_dropped)
   );

endmodule
